/* rtl/ctb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants for the countdown timer bank
// Command and result codes, the beat held during a command, and the
// link and event records that travel along the row of timer cells.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;

  // At most this many fire results are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int SLOT_W    = 4;
  localparam int ELAPSED_W = 32;
  localparam int ARM_W     = 48;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ARMED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_DISARMED = 3'd2,
    KIND_FIRED    = 3'd3,
    KIND_IDLE     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // Command fields broadcast to every cell while a command is in flight.
  typedef struct packed {
    cmd_e                  op;
    logic [SLOT_W-1:0]     slot;
    logic [ELAPSED_W-1:0]  elapsed;
  } bank_cmd_t;

  // Handed from one cell to the next every cycle.
  typedef struct packed {
    logic turn;    // the command is at this cell in this cycle
    logic placed;  // an arm command has already found its slot
  } link_t;

  // What a cell did during its turn.
  typedef struct packed {
    logic fire;
    logic armed;
  } cell_ev_t;

endpackage

/* rtl/ctb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_cell: one timer slot of the countdown timer bank
// Holds the remaining time, reload period and status of one timer, and acts
// on the broadcast command in the cycle that the turn token reaches it.
// ----------------------------------------------------------------------------
module ctb_cell
  import ctb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  link_t                link_i,
  output link_t                link_o,
  input  bank_cmd_t            cmd_i,
  input  logic [TIME_BITS-1:0] dur_i,
  input  logic [TIME_BITS-1:0] rel_i,
  output cell_ev_t             ev_o
);

  localparam int EXT_W = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;

  logic                 turn_r;
  logic                 placed_r;
  logic                 occ_r, occ_nxt;
  logic                 fired_r, fired_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] rel_r, rel_nxt;

  logic [EXT_W-1:0]     diff;
  logic                 expired;
  cell_ev_t             ev;

  // A borrow or an exact zero both mean the timer ran out.
  assign diff    = EXT_W'(rem_r) - EXT_W'(cmd_i.elapsed);
  assign expired = diff[EXT_W-1] || (diff == '0);

  always_comb begin
    occ_nxt   = occ_r;
    fired_nxt = fired_r;
    rem_nxt   = rem_r;
    rel_nxt   = rel_r;
    ev        = '0;
    if (turn_r) begin
      case (cmd_i.op)
        CMD_ARM: begin
          if (!occ_r && !placed_r) begin
            occ_nxt   = 1'b1;
            fired_nxt = 1'b0;
            rem_nxt   = dur_i;
            rel_nxt   = rel_i;
            ev.armed  = 1'b1;
          end
        end
        CMD_DISARM: begin
          if (32'(cmd_i.slot) == IDX) begin
            occ_nxt   = 1'b0;
            fired_nxt = 1'b0;
          end
        end
        CMD_TICK: begin
          if (occ_r && !fired_r) begin
            if (expired) begin
              ev.fire = 1'b1;
              if (rel_r != '0) begin
                rem_nxt = rel_r;
              end else begin
                rem_nxt   = '0;
                fired_nxt = 1'b1;
              end
            end else begin
              rem_nxt = diff[TIME_BITS-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ev_o          = ev;
  assign link_o.turn   = turn_r;
  assign link_o.placed = placed_r || ev.armed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r   <= 1'b0;
      placed_r <= 1'b0;
      occ_r    <= 1'b0;
      fired_r  <= 1'b0;
    end else begin
      turn_r   <= link_i.turn;
      placed_r <= link_i.placed;
      occ_r    <= occ_nxt;
      fired_r  <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    rel_r <= rel_nxt;
  end

  // A one-shot timer that has fired is never counted down again.
  assert property (@(posedge clk) disable iff (!rst_n)
    (turn_r && cmd_i.op == CMD_TICK && fired_r) |-> !ev.fire)
    else $error("ctb_cell: fired one-shot timer fired again");

  // A slot that is already in use is never taken by an arm.
  assert property (@(posedge clk) disable iff (!rst_n)
    ev.armed |=> (occ_r && !fired_r && !$past(occ_r)))
    else $error("ctb_cell: arm placed into an occupied slot");

  // The arm search stops at the first free slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (turn_r && placed_r) |-> !ev.armed)
    else $error("ctb_cell: arm placed twice");

endmodule

/* rtl/countdown_timer_bank_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_bank_top: bank of command-driven countdown timers
// Arm, disarm and tick commands act on a row of timer cells that a turn
// token walks through one cell per cycle; fire reports come out in slot order.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Fields
//  ---------+----------------------+--------------------------------------------
//  command  | start / busy         | in_cmd, in_slot, in_duration_ns,
//           |                      | in_reload_ns, in_elapsed_ns
//  result   | out_valid (strobe)   | out_kind, out_slot_id, out_last
//
// A command beat is taken at a rising edge with start high and busy low.
// The turn token then crosses the row of NUM_TIMERS cells one cell per
// cycle, and a closing state closes out the final result. A new command
// may be taken at the edge that ends that closing state. Each report waits
// in a pending register until the next report of the same command or the
// closing cycle pushes it out, so a beat shows up in the cycle after the
// cell of the following report, or in the cycle after the closing cycle
// for the final beat. Each result beat is valid for exactly one cycle and
// must be taken then, since the receiver cannot stall the bank.
// Reset (synchronous, active low) frees every slot and clears all fired
// marks; the stored times of a slot are only meaningful once it is armed.
// An unused command code runs the token through the row and gives no result.
// ----------------------------------------------------------------------------
module countdown_timer_bank_top
  import ctb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [ARM_W-1:0]     in_duration_ns,
  input  logic [ARM_W-1:0]     in_reload_ns,
  input  logic [ELAPSED_W-1:0] in_elapsed_ns,
  output logic                 out_valid,
  output logic [2:0]           out_kind,
  output logic [SLOT_W-1:0]    out_slot_id,
  output logic                 out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Control state.
  state_e             state_r, state_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers.
  bank_cmd_t            cmd_r;
  logic [TIME_BITS-1:0] dur_r;
  logic [TIME_BITS-1:0] rel_r;
  kind_e                pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  kind_e                out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                  accept;
  logic                  chain_done;
  logic                  ev_fire;
  logic                  ev_armed;
  logic                  cap_fire;
  link_t                 link [NUM_TIMERS+1];
  cell_ev_t              ev   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] turn_vec;

  // The bank can take a command while it closes out the previous one.
  assign accept = start && (state_r != ST_RUN);
  assign busy   = (state_r == ST_RUN);

  // The token enters the first cell in the cycle right after acceptance.
  assign link[0].turn   = accept;
  assign link[0].placed = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    ctb_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX       (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .cmd_i  (cmd_r),
      .dur_i  (dur_r),
      .rel_i  (rel_r),
      .ev_o   (ev[i])
    );
    assign turn_vec[i] = link[i+1].turn;
  end

  // Only the cell holding the token raises an event, so a plain OR suffices.
  always_comb begin
    ev_fire  = 1'b0;
    ev_armed = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ev_fire  = ev_fire  || ev[i].fire;
      ev_armed = ev_armed || ev[i].armed;
    end
  end

  assign chain_done = link[NUM_TIMERS].turn;
  assign cap_fire   = ev_fire && (fcnt_r < FCNT_W'(MAX_RESULTS));

  // Each new report pushes the one before it out with last low; the report
  // still pending when the token leaves the row becomes the final beat.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fcnt_nxt      = fcnt_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
      end
      ST_RUN: begin
        pos_nxt = pos_r + 1'b1;
        if (cap_fire || ev_armed) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_slot_nxt  = pend_slot_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_kind_nxt = ev_armed ? KIND_ARMED : KIND_FIRED;
          pend_slot_nxt = SLOT_W'(pos_r);
          if (cap_fire) begin
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end
        if (chain_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
        case (cmd_r.op)
          CMD_TICK: begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_kind_nxt  = pend_v_r ? pend_kind_r : KIND_IDLE;
            out_slot_nxt  = pend_v_r ? pend_slot_r : '0;
          end
          CMD_ARM: begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_kind_nxt  = pend_v_r ? pend_kind_r : KIND_FULL;
            out_slot_nxt  = pend_v_r ? pend_slot_r : '0;
          end
          CMD_DISARM: begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_kind_nxt  = KIND_DISARMED;
            out_slot_nxt  = cmd_r.slot;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (accept) begin
      state_nxt  = ST_RUN;
      pos_nxt    = '0;
      fcnt_nxt   = '0;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      fcnt_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fcnt_r      <= fcnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The command beat is held for the whole walk; arm times are cut or
  // widened to the timer width here.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op      <= cmd_e'(in_cmd);
      cmd_r.slot    <= in_slot;
      cmd_r.elapsed <= in_elapsed_ns;
      dur_r         <= TIME_BITS'(in_duration_ns);
      rel_r         <= TIME_BITS'(in_reload_ns);
    end
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot_id = out_slot_r;
  assign out_last    = out_last_r;

  // The turn token is never in two cells at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(turn_vec))
    else $error("countdown_timer_bank_top: turn token duplicated");

  // Every real command ends with exactly one final beat after the walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && cmd_r.op != CMD_NONE) |=> (out_valid && out_last))
    else $error("countdown_timer_bank_top: final result missing");

  // The cycle after a final beat belongs to a fresh command with nothing pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("countdown_timer_bank_top: result after final beat");

  // The fire report count never exceeds the per-tick limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(MAX_RESULTS))
    else $error("countdown_timer_bank_top: too many fire reports");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for countdown_timer_bank_top
// Named tests send arm, disarm and tick command beats through the start/busy
// handshake. A shadow copy of the timer bank predicts every result beat, and
// a checker compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ctb_pkg::*;

  // Generous bound on the whole run: about 230 commands, each walking the
  // bank after a random idle gap before it is offered.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 180;
  localparam logic [ARM_W-1:0]     TIME_MAX    = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // One expected result beat.
  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] slot_id;
    logic              last;
  } timer_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_cmd = CMD_TICK;
  logic [SLOT_W-1:0]    in_slot = '0;
  logic [ARM_W-1:0]     in_duration_ns = '0;
  logic [ARM_W-1:0]     in_reload_ns = '0;
  logic [ELAPSED_W-1:0] in_elapsed_ns = '0;
  logic                 out_valid;
  logic [2:0]           out_kind;
  logic [SLOT_W-1:0]    out_slot_id;
  logic                 out_last;

  // Shadow state of the bank, updated as each command beat is accepted.
  logic [ARM_W-1:0] shadow_remaining [NUM_TIMERS_DEF];
  logic [ARM_W-1:0] shadow_reload    [NUM_TIMERS_DEF];
  logic             shadow_occupied  [NUM_TIMERS_DEF];
  logic             shadow_fired     [NUM_TIMERS_DEF];

  // Result beats that the accepted commands still owe, oldest first.
  timer_report_t pending_reports[$];

  int  error_count = 0;
  int  cycle_count = 0;
  // While set, commands are offered back to back with no idle gap.
  bit  back_to_back = 1'b0;

  countdown_timer_bank_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_slot       (in_slot),
    .in_duration_ns(in_duration_ns),
    .in_reload_ns  (in_reload_ns),
    .in_elapsed_ns (in_elapsed_ns),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_slot_id   (out_slot_id),
    .out_last      (out_last)
  );

  // 4 ns clock: low for 2 ns, high for 2 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic timer_report_t make_report(kind_e kind, int slot_id);
    timer_report_t r;
    r.kind    = kind;
    r.slot_id = slot_id[SLOT_W-1:0];
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic void clear_shadow_bank();
    for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
      shadow_remaining[i] = '0;
      shadow_reload[i]    = '0;
      shadow_occupied[i]  = 1'b0;
      shadow_fired[i]     = 1'b0;
    end
  endfunction

  // Applies one accepted command to the shadow bank and queues the result
  // beats that it causes. The final beat of each command carries last.
  function automatic void predict_timer_reports(cmd_e cmd, logic [SLOT_W-1:0] slot,
                                                logic [ARM_W-1:0] duration,
                                                logic [ARM_W-1:0] reload,
                                                logic [ELAPSED_W-1:0] elapsed);
    timer_report_t batch[$];
    int free_slot;
    logic [ARM_W-1:0] elapsed_w;
    free_slot = -1;
    elapsed_w = ARM_W'(elapsed);
    case (cmd)
      CMD_ARM: begin
        // The lowest free slot takes the new timer.
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
          if (!shadow_occupied[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          shadow_remaining[free_slot] = duration;
          shadow_reload[free_slot]    = reload;
          shadow_occupied[free_slot]  = 1'b1;
          shadow_fired[free_slot]     = 1'b0;
          batch.push_back(make_report(KIND_ARMED, free_slot));
        end else begin
          batch.push_back(make_report(KIND_FULL, 0));
        end
      end
      CMD_DISARM: begin
        shadow_occupied[slot] = 1'b0;
        shadow_fired[slot]    = 1'b0;
        batch.push_back(make_report(KIND_DISARMED, int'(slot)));
      end
      CMD_TICK: begin
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
          if (shadow_occupied[i] && !shadow_fired[i]) begin
            // Count down, saturating at zero.
            if (elapsed_w >= shadow_remaining[i]) shadow_remaining[i] = '0;
            else shadow_remaining[i] = shadow_remaining[i] - elapsed_w;
            if (shadow_remaining[i] == '0) begin
              if (batch.size() < MAX_RESULTS) batch.push_back(make_report(KIND_FIRED, i));
              // A periodic timer reloads and keeps running; a one-shot timer
              // stays fired until it is disarmed.
              if (shadow_reload[i] != '0) shadow_remaining[i] = shadow_reload[i];
              else shadow_fired[i] = 1'b1;
            end
          end
        end
        if (batch.size() == 0) batch.push_back(make_report(KIND_IDLE, 0));
      end
      default: begin
        // The unused code gives no result at all.
      end
    endcase
    if (batch.size() != 0) begin
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) pending_reports.push_back(batch[k]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. The bank cannot be stalled, so every strobed beat is
  // taken at the edge that ends its cycle and matched against the oldest
  // prediction. Outputs are sampled at the edge, before any update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    timer_report_t exp_report;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result beat: kind %0d slot_id %0d last %0b",
                 out_kind, out_slot_id, out_last);
          error_count++;
        end else begin
          exp_report = pending_reports.pop_front();
          if (out_kind !== exp_report.kind) begin
            $error("out_kind: expected %0d, actual %0d", exp_report.kind, out_kind);
            error_count++;
          end
          if (out_slot_id !== exp_report.slot_id) begin
            $error("out_slot_id: expected %0d, actual %0d", exp_report.slot_id, out_slot_id);
            error_count++;
          end
          if (out_last !== exp_report.last) begin
            $error("out_last: expected %0b, actual %0b", exp_report.last, out_last);
            error_count++;
          end
        end
      end else if (out_valid !== 1'b0) begin
        $error("out_valid: expected 0 or 1, actual %b", out_valid);
        error_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------

  // Offers one command beat and returns at the edge that accepts it. The
  // task is entered and left at a rising edge. Start is lowered only when an
  // idle gap follows, so it never gets two assignments in one time step.
  task automatic send_command(cmd_e cmd, logic [SLOT_W-1:0] slot,
                              logic [ARM_W-1:0] duration, logic [ARM_W-1:0] reload,
                              logic [ELAPSED_W-1:0] elapsed);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_slot        <= slot;
    in_duration_ns <= duration;
    in_reload_ns   <= reload;
    in_elapsed_ns  <= elapsed;
    // The beat moves at the first edge that sees busy low.
    do @(posedge clk); while (busy !== 1'b0);
    predict_timer_reports(cmd, slot, duration, reload, elapsed);
  endtask

  task automatic send_arm(logic [ARM_W-1:0] duration, logic [ARM_W-1:0] reload);
    send_command(CMD_ARM, SLOT_W'($urandom), duration, reload, ELAPSED_W'($urandom));
  endtask

  task automatic send_disarm(logic [SLOT_W-1:0] slot);
    send_command(CMD_DISARM, slot, ARM_W'({$urandom, $urandom}),
                 ARM_W'({$urandom, $urandom}), ELAPSED_W'($urandom));
  endtask

  task automatic send_tick(logic [ELAPSED_W-1:0] elapsed);
    send_command(CMD_TICK, SLOT_W'($urandom), ARM_W'({$urandom, $urandom}),
                 ARM_W'({$urandom, $urandom}), elapsed);
  endtask

  // --------------------------------------------------------------------------
  // Random value sources
  // --------------------------------------------------------------------------

  // Mostly short durations so timers fire often, now and then a value that
  // spans all 48 bits.
  function automatic logic [ARM_W-1:0] random_duration();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode <= 6) return ARM_W'($urandom_range(1, 3000));
    if (mode <= 8) return ARM_W'($urandom_range(1, 1 << 20));
    return ARM_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode <= 7) return ELAPSED_W'($urandom_range(0, 2000));
    if (mode == 8) return ELAPSED_W'($urandom_range(0, 100000));
    return $urandom;
  endfunction

  // Picks an armed slot most of the time, any slot otherwise.
  function automatic logic [SLOT_W-1:0] random_disarm_slot();
    int base;
    base = $urandom_range(0, NUM_TIMERS_DEF - 1);
    if ($urandom_range(0, 4) != 0) begin
      for (int k = 0; k < NUM_TIMERS_DEF; k++) begin
        if (shadow_occupied[(base + k) % NUM_TIMERS_DEF])
          return SLOT_W'((base + k) % NUM_TIMERS_DEF);
      end
    end
    return SLOT_W'(base);
  endfunction

  function automatic int armed_count();
    int n;
    n = 0;
    foreach (shadow_occupied[i]) n += shadow_occupied[i];
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every command on a quiet bank, with the widest field values.
  task automatic test_basic_commands();
    send_tick(ELAPSED_MAX);                 // empty bank: tick without firing
    send_command(CMD_NONE, '1, TIME_MAX, TIME_MAX, ELAPSED_MAX);  // ignored
    send_disarm(SLOT_W'(5));                // disarm of a free slot
    send_arm(TIME_MAX, TIME_MAX);           // slot 0, longest possible timer
    send_tick(ELAPSED_MAX);                 // counts down, no fire
    send_disarm(SLOT_W'(0));
    send_disarm(SLOT_W'(NUM_TIMERS_DEF - 1));
  endtask

  // One-shot timers: zero duration, exact expiry, and re-arm of a fired slot.
  task automatic test_one_shot_rules();
    send_arm('0, '0);                       // slot 0, zero duration
    send_tick('0);                          // fires even with nothing elapsed
    send_tick(ELAPSED_W'(100));             // stays fired: tick without firing
    send_arm(ARM_W'(10), '0);               // slot 1
    send_tick(ELAPSED_W'(10));              // reaches zero exactly
    send_disarm(SLOT_W'(0));
    send_arm(ARM_W'(5), '0);                // slot 0 again, fired mark cleared
    send_tick(ELAPSED_W'(3));
    send_tick(ELAPSED_W'(2));
    send_disarm(SLOT_W'(0));
    send_disarm(SLOT_W'(1));
  endtask

  // A periodic timer reloads in place and is not counted down in the same tick.
  task automatic test_periodic_reload();
    send_arm(ARM_W'(4), ARM_W'(7));         // slot 0
    send_tick(ELAPSED_W'(10));              // overshoot saturates, fires, reloads
    send_tick(ELAPSED_W'(6));               // 7 - 6 leaves one
    send_tick(ELAPSED_W'(1));               // fires again
    send_disarm(SLOT_W'(0));
  endtask

  // Fill every slot, overflow the bank, then fire all sixteen in one tick.
  task automatic test_bank_full();
    for (int i = 0; i < NUM_TIMERS_DEF; i++) send_arm('0, ARM_W'(i % 2));
    send_arm(ARM_W'(1), '0);                // bank full
    send_tick('0);                          // the most results one beat can cause
    send_tick(ELAPSED_W'(1));               // only the periodic half fires
  endtask

  // Mixed traffic. The mix leans toward arming on a sparse bank and toward
  // disarming on a crowded one, so the bank keeps moving between empty and
  // full. Idle gaps are random, with back-to-back stretches now and then.
  task automatic test_random_traffic();
    int sent;
    int pick;
    int occ;
    int arm_weight;
    int disarm_weight;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 20 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      occ = armed_count();
      arm_weight    = (occ < 4) ? 50 : (occ > 12) ? 15 : 32;
      disarm_weight = (occ > 12) ? 45 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_command(CMD_NONE, SLOT_W'($urandom), ARM_W'({$urandom, $urandom}),
                     ARM_W'({$urandom, $urandom}), $urandom);
      end else begin
        if (pick < 4 + arm_weight) begin
          send_arm(random_duration(), ($urandom_range(0, 99) < 45) ? '0 : random_duration());
        end else if (pick < 4 + arm_weight + disarm_weight) begin
          send_disarm(random_disarm_slot());
        end else begin
          send_tick(random_elapsed());
        end
        sent++;
      end
    end
    back_to_back = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_shadow_bank();
    // Reset is held low from time zero and released at a rising edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_one_shot_rules();
    test_periodic_reload();
    test_bank_full();
    test_random_traffic();

    // The last beat was accepted at this edge; stop offering commands.
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Let a full pass through the row go by, so a stray extra beat is seen.
    repeat (2 * NUM_TIMERS_DEF + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ctb_pkg.sv
rtl/ctb_cell.sv
rtl/countdown_timer_bank_top.sv
tb/testbench.sv
